// ----- hw/rtl/prtpb_pkg.sv -----
// shared types and constants for the parent route table path builder
// depends on nothing; imported by the controller, datapath and top level
package prtpb_pkg;

  // operation codes of an input item
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_LOOKUP = 3'd1;
  localparam logic [2:0] OP_PATH   = 3'd2;
  localparam logic [2:0] OP_AGE    = 3'd3;
  localparam logic [2:0] OP_ORPHAN = 3'd4;
  localparam logic [2:0] OP_TICK   = 3'd5;

  // outcome codes of a result item
  localparam logic [2:0] OC_DONE      = 3'd0;
  localparam logic [2:0] OC_INSERTED  = 3'd1;
  localparam logic [2:0] OC_CHANGED   = 3'd2;
  localparam logic [2:0] OC_UNCHANGED = 3'd3;
  localparam logic [2:0] OC_FULL      = 3'd4;
  localparam logic [2:0] OC_MISSING   = 3'd5;
  localparam logic [2:0] OC_TOO_LONG  = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_ROOT   = 2'd0;
  localparam logic [1:0] CFG_PERIOD = 2'd1;
  localparam logic [1:0] CFG_NURSE  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,     // walk table entries one per cycle, pausing for orphan inner searches
    ST_DECIDE,   // act on a finished scan
    ST_ORPH_IN,  // orphan pass: inner search for parent
    ST_EMIT,     // send result items
    ST_WAIT      // wait for final transfer
  } state_t;

  // command from controller to datapath
  typedef struct packed {
    logic start;      // latch input item, reset scan index
    logic scan_step;  // advance scan index
    logic inner_start;
    logic inner_step;
    logic apply;      // perform the decision for current op
    logic path_next;  // follow parent link
    logic orph_kill;  // remove current orphan entry
    logic orph_keep;  // advance outer index
    logic pass_restart;
    logic emit_load;  // load output register
    logic emit_step;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic scan_done;
    logic scan_hit;
    logic inner_done;
    logic inner_hit;
    logic path_at_root;
    logic path_fail;
    logic outer_done;
    logic outer_skip;
    logic pass_changed;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage

// ----- hw/rtl/prtpb_ctrl.sv -----
// controller state machine for the parent route table path builder
// depends on prtpb_pkg for state, command and status types
module prtpb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  prtpb_pkg::stat_t st,
  output prtpb_pkg::cmd_t  cmd,
  output logic            busy
);
  import prtpb_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (st.op == OP_ORPHAN) begin
          if (st.outer_done) begin
            if (st.pass_changed) cmd.pass_restart = 1'b1;
            else state_nxt = ST_DECIDE;
          end else if (st.outer_skip) begin
            cmd.orph_keep = 1'b1;
          end else begin
            cmd.inner_start = 1'b1;
            state_nxt = ST_ORPH_IN;
          end
        end else if (st.op == OP_PATH) begin
          if (st.path_at_root || st.path_fail) state_nxt = ST_DECIDE;
          else if (st.scan_done || st.scan_hit) begin
            cmd.path_next = 1'b1;
          end else cmd.scan_step = 1'b1;
        end else if (st.op == OP_AGE) begin
          if (st.scan_done) state_nxt = ST_DECIDE;
          else cmd.scan_step = 1'b1;
        end else if (st.op == OP_ADD || st.op == OP_LOOKUP) begin
          if (st.scan_done || st.scan_hit) state_nxt = ST_DECIDE;
          else cmd.scan_step = 1'b1;
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_ORPH_IN: begin
        if (st.inner_hit) begin
          cmd.orph_keep = 1'b1;
          state_nxt = ST_SCAN;
        end else if (st.inner_done) begin
          cmd.orph_kill = 1'b1;
          state_nxt = ST_SCAN;
        end else cmd.inner_step = 1'b1;
      end
      ST_DECIDE: begin
        cmd.apply = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit_load = 1'b1;
          if (st.emit_last) state_nxt = ST_WAIT;
          else cmd.emit_step = 1'b1;
        end
      end
      ST_WAIT: begin
        if (st.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ----- hw/rtl/prtpb_dp.sv -----
// datapath for the parent route table path builder: table, path store, outputs
// depends on prtpb_pkg for codes and command and status types
module prtpb_dp #(
  parameter int TABLE_ENTRIES = 32,
  parameter int PATH_HOPS     = 16,
  parameter int ADDR_BITS     = 64,
  parameter int TIME_BITS     = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  prtpb_pkg::cmd_t      cmd,
  output prtpb_pkg::stat_t     st,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic [2:0]           i_op,
  input  logic [ADDR_BITS-1:0] i_node,
  input  logic [ADDR_BITS-1:0] i_parent,
  input  logic [7:0]           i_hop_limit,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic                 o_ok,
  output logic [2:0]           o_outcome,
  output logic [ADDR_BITS-1:0] o_addr,
  output logic [4:0]           o_hops,
  output logic                 o_nurse,
  output logic                 o_last
);
  import prtpb_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int PW = $clog2(PATH_HOPS + 1);
  localparam int SW = (PATH_HOPS > 1) ? $clog2(PATH_HOPS) : 1;

  // configuration registers
  logic [ADDR_BITS-1:0] root_r, nurse_r;
  logic [31:0]          period_r;
  logic [TIME_BITS-1:0] tick_r;

  // table: valid bits in flops, payload in arrays
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [ADDR_BITS-1:0] child_r  [TABLE_ENTRIES];
  logic [ADDR_BITS-1:0] parent_r [TABLE_ENTRIES];
  logic [TIME_BITS-1:0] seen_r   [TABLE_ENTRIES];
  logic [ADDR_BITS-1:0] path_r   [PATH_HOPS];

  // item state
  logic [2:0]           op_r;
  logic [ADDR_BITS-1:0] node_r, par_r, cur_r;
  logic [7:0]           maxh_r;
  logic [IW:0]          idx_r, jdx_r;
  logic [PW-1:0]        n_r, k_r;
  logic                 any_r, nurse_hit_r, changed_r, fail_r;
  logic [2:0]           fail_oc_r;
  logic [IW:0]          free_r;

  logic [IW-1:0] ix, jx;
  assign ix = idx_r[IW-1:0];
  assign jx = jdx_r[IW-1:0];

  logic [PW-1:0] limit;
  assign limit = (int'(maxh_r) < PATH_HOPS) ? PW'(maxh_r) : PW'(PATH_HOPS);

  // age wraps at the time width, period is compared unsigned
  logic [TIME_BITS-1:0] age;
  logic scan_done, scan_hit, aged;
  assign age = tick_r - seen_r[ix];
  assign scan_done = idx_r == (IW+1)'(TABLE_ENTRIES);
  assign scan_hit  = !scan_done && valid_r[ix] &&
                     child_r[ix] == ((op_r == OP_PATH) ? cur_r : node_r);
  assign aged = 64'(age) > 64'(period_r);

  // status
  always_comb begin
    st = '0;
    st.op = op_r;
    st.scan_done = scan_done;
    st.scan_hit = scan_hit;
    st.inner_done = jdx_r == (IW+1)'(TABLE_ENTRIES);
    st.inner_hit = !st.inner_done && valid_r[jx] && child_r[jx] == parent_r[ix];
    st.path_at_root = cur_r == root_r;
    st.path_fail = fail_r;
    st.outer_done = scan_done;
    st.outer_skip = !scan_done && (!valid_r[ix] || parent_r[ix] == root_r);
    st.pass_changed = changed_r;
    st.emit_last = (op_r != OP_PATH) || fail_r || n_r == '0 ||
                   k_r == n_r - PW'(1);
    st.out_free = !out_tvalid || out_tready;
  end

  // configuration and tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= '0; nurse_r <= '0; period_r <= 32'd1024; tick_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROOT:   root_r <= cfg_data[ADDR_BITS-1:0];
          CFG_PERIOD: period_r <= cfg_data[31:0];
          CFG_NURSE:  nurse_r <= cfg_data[ADDR_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd.apply && op_r == OP_TICK) tick_r <= tick_r + TIME_BITS'(1);
    end
  end

  // control-side item registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0; idx_r <= '0; jdx_r <= '0; n_r <= '0; k_r <= '0;
      any_r <= 1'b0; nurse_hit_r <= 1'b0; changed_r <= 1'b0; fail_r <= 1'b0;
      free_r <= '0; fail_oc_r <= OC_DONE; op_r <= OP_TICK;
    end else begin
      if (cmd.start) begin
        op_r <= i_op; idx_r <= '0; n_r <= '0; k_r <= '0; any_r <= 1'b0;
        nurse_hit_r <= 1'b0; changed_r <= 1'b0; fail_r <= 1'b0;
        free_r <= (IW+1)'(TABLE_ENTRIES);
      end
      if (cmd.scan_step) begin
        // remember lowest free slot seen during a scan; only add uses it
        if (!valid_r[ix] && free_r == (IW+1)'(TABLE_ENTRIES)) free_r <= idx_r;
        if (op_r == OP_AGE && valid_r[ix] && aged) begin
          valid_r[ix] <= 1'b0;
          any_r <= 1'b1;
          if (child_r[ix] == nurse_r) nurse_hit_r <= 1'b1;
        end
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.path_next) begin
        // one hop of the walk: limit, missing, self loop
        idx_r <= '0;
        if (n_r >= limit) begin
          fail_r <= 1'b1; fail_oc_r <= OC_TOO_LONG;
        end else begin
          n_r <= n_r + PW'(1);
          if (!scan_hit) begin
            fail_r <= 1'b1; fail_oc_r <= OC_MISSING;
          end else if (parent_r[ix] == cur_r) begin
            fail_r <= 1'b1; fail_oc_r <= OC_TOO_LONG;
          end
        end
      end
      if (cmd.inner_start) jdx_r <= '0;
      if (cmd.inner_step) jdx_r <= jdx_r + 1'b1;
      if (cmd.orph_kill) begin
        valid_r[ix] <= 1'b0; changed_r <= 1'b1; any_r <= 1'b1;
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.orph_keep) idx_r <= idx_r + 1'b1;
      if (cmd.pass_restart) begin
        idx_r <= '0; changed_r <= 1'b0;
      end
      if (cmd.apply && op_r == OP_ADD && !scan_hit &&
          free_r != (IW+1)'(TABLE_ENTRIES))
        valid_r[free_r[IW-1:0]] <= 1'b1;
      if (cmd.emit_step) k_r <= k_r + PW'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      node_r <= i_node; par_r <= i_parent; maxh_r <= i_hop_limit; cur_r <= i_node;
    end
    if (cmd.path_next && scan_hit && n_r < limit) cur_r <= parent_r[ix];
    if (cmd.path_next && n_r < limit) path_r[n_r[SW-1:0]] <= cur_r;
    if (cmd.apply && op_r == OP_ADD) begin
      if (scan_hit) begin
        seen_r[ix] <= tick_r; parent_r[ix] <= par_r;
      end else if (free_r != (IW+1)'(TABLE_ENTRIES)) begin
        child_r[free_r[IW-1:0]] <= node_r;
        parent_r[free_r[IW-1:0]] <= par_r;
        seen_r[free_r[IW-1:0]] <= tick_r;
      end
    end
  end

  // result register
  logic                 ok_r;
  logic [2:0]           oc_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [4:0]           hops_r;
  logic                 nur_r, last_r, hit_r;
  logic                 valid_o_r;
  logic                 same_par_r;

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      same_par_r <= scan_hit && parent_r[ix] == par_r;
      hit_r <= scan_hit;
      addr_r <= scan_hit ? parent_r[ix] : '0;
    end
    if (cmd.emit_load) begin
      last_r <= st.emit_last;
      nur_r <= 1'b0; hops_r <= '0; ok_r <= 1'b0; oc_r <= OC_DONE;
      unique case (op_r)
        OP_ADD: begin
          if (hit_r) begin
            ok_r <= !same_par_r;
            oc_r <= same_par_r ? OC_UNCHANGED : OC_CHANGED;
          end else if (free_r != (IW+1)'(TABLE_ENTRIES)) begin
            ok_r <= 1'b1; oc_r <= OC_INSERTED;
          end else oc_r <= OC_FULL;
          addr_r <= '0;
        end
        OP_LOOKUP: begin
          ok_r <= hit_r; oc_r <= hit_r ? OC_DONE : OC_MISSING;
        end
        OP_PATH: begin
          addr_r <= '0;
          if (fail_r) oc_r <= fail_oc_r;
          else begin
            ok_r <= 1'b1;
            if (n_r != '0) begin
              addr_r <= path_r[SW'(n_r - PW'(1) - k_r)];
              hops_r <= 5'(n_r);
            end
          end
        end
        OP_AGE: begin
          ok_r <= any_r; nur_r <= nurse_hit_r; addr_r <= '0;
        end
        OP_ORPHAN: begin
          ok_r <= any_r; addr_r <= '0;
        end
        default: addr_r <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_o_r <= 1'b0;
    else if (cmd.emit_load) valid_o_r <= 1'b1;
    else if (out_tready) valid_o_r <= 1'b0;
  end

  assign out_tvalid = valid_o_r;
  assign o_ok = ok_r;
  assign o_outcome = oc_r;
  assign o_addr = addr_r;
  assign o_hops = hops_r;
  assign o_nurse = nur_r;
  assign o_last = last_r;
endmodule

// ----- hw/rtl/parent_route_table_path_builder.sv -----
// Route table with path build and pruning; one input item in flight at a time.
// Add, lookup and aging walk the table serially; a path build walks it once per hop
// and then sends one hop per cycle while out_tready is high; orphan pruning repeats
// its passes until a pass removes nothing. Next item accepted the cycle after the
// final result transfer. Reset (rst_n, sync) clears valid bits and tick.
module parent_route_table_path_builder #(
  parameter int TABLE_ENTRIES = 32,
  parameter int PATH_HOPS     = 16,
  parameter int ADDR_BITS     = 64,
  parameter int TIME_BITS     = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [63:0]                 cfg_data,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // op, node_addr, parent_addr, hop_limit, zero fill
  input  logic [2*ADDR_BITS+15:0]     in_tdata,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  // ok, outcome, addr_out, hop_count, nurse_pruned
  output logic [ADDR_BITS+15:0]       out_tdata,
  output logic                        out_tlast
);
  import prtpb_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic  busy, in_fire;
  logic  ok, nur;
  logic [2:0] oc;
  logic [ADDR_BITS-1:0] addr;
  logic [4:0] hops;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;

  prtpb_ctrl u_ctrl (.clk, .rst_n, .in_fire, .st, .cmd, .busy);

  prtpb_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .PATH_HOPS(PATH_HOPS),
             .ADDR_BITS(ADDR_BITS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk, .rst_n, .cmd, .st, .cfg_we, .cfg_index, .cfg_data,
    .i_op(in_tdata[2:0]),
    .i_node(in_tdata[ADDR_BITS+2:3]),
    .i_parent(in_tdata[2*ADDR_BITS+2:ADDR_BITS+3]),
    .i_hop_limit(in_tdata[2*ADDR_BITS+10:2*ADDR_BITS+3]),
    .out_tvalid, .out_tready,
    .o_ok(ok), .o_outcome(oc), .o_addr(addr), .o_hops(hops),
    .o_nurse(nur), .o_last(out_tlast)
  );

  assign out_tdata = {6'd0, nur, hops, addr, oc, ok};
endmodule
